// File: sv/tre_pkg.sv
// ----------------------------------------------------------------------------
// tre_pkg
// Shared constants and types for the Toeplitz randomness extractor.
// ----------------------------------------------------------------------------
package tre_pkg;

  // Fixed field widths on the ports
  localparam int unsigned RAW_FIELD_W = 64;
  localparam int unsigned OUT_FIELD_W = 32;
  localparam int unsigned LFSR_W      = 32;

  // Default generics
  localparam int unsigned RAW_WIDTH_DEF = 64;
  localparam int unsigned OUT_WIDTH_DEF = 32;

  // LFSR: start value after reset and the two upper feedback taps
  localparam logic [LFSR_W-1:0] LFSR_RESET = 32'hBEEF_1234;
  localparam int unsigned       TAP_A      = 21;
  localparam int unsigned       TAP_B      = 31;

  // Seed generator states, one-hot
  typedef enum logic [1:0] {
    SG_BUILD = 2'b01,
    SG_READY = 2'b10
  } sg_state_t;

endpackage

// File: sv/tre_seed_gen.sv
// ----------------------------------------------------------------------------
// tre_seed_gen
// Expands the LFSR start value into the Toeplitz seed, one seed bit a cycle.
// ----------------------------------------------------------------------------
module tre_seed_gen #(
  parameter int unsigned SEED_W = tre_pkg::RAW_WIDTH_DEF + tre_pkg::OUT_WIDTH_DEF - 1
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_tvalid,
  output logic                        cfg_tready,
  input  logic [tre_pkg::LFSR_W-1:0]  cfg_tdata,
  output logic [SEED_W-1:0]           seed,
  output logic                        seed_ok
);

  localparam int unsigned CNT_W = (SEED_W > 1) ? $clog2(SEED_W) : 1;

  tre_pkg::sg_state_t          state_r, state_nxt;
  logic [tre_pkg::LFSR_W-1:0]  lfsr_r, lfsr_nxt;
  logic [CNT_W-1:0]            cnt_r, cnt_nxt;
  logic [SEED_W-1:0]           seed_r, seed_nxt;
  logic                        fb;

  assign cfg_tready = 1'b1;
  assign seed       = seed_r;
  assign seed_ok    = (state_r == tre_pkg::SG_READY);

  assign fb = lfsr_r[0] ^ lfsr_r[1] ^ lfsr_r[tre_pkg::TAP_A] ^ lfsr_r[tre_pkg::TAP_B];

  always_comb begin
    state_nxt = state_r;
    lfsr_nxt  = lfsr_r;
    cnt_nxt   = cnt_r;
    seed_nxt  = seed_r;
    case (state_r)
      tre_pkg::SG_BUILD: begin
        // seed bit k lands at index k after SEED_W shifts
        seed_nxt = {lfsr_r[0], seed_r[SEED_W-1:1]};
        lfsr_nxt = {fb, lfsr_r[tre_pkg::LFSR_W-1:1]};
        cnt_nxt  = cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(SEED_W - 1)) begin
          state_nxt = tre_pkg::SG_READY;
        end
      end
      tre_pkg::SG_READY: begin
      end
      default: begin
        state_nxt = tre_pkg::SG_BUILD;
        cnt_nxt   = '0;
      end
    endcase
    // a new start value restarts the expansion
    if (cfg_tvalid) begin
      state_nxt = tre_pkg::SG_BUILD;
      lfsr_nxt  = cfg_tdata;
      cnt_nxt   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tre_pkg::SG_BUILD;
      lfsr_r  <= tre_pkg::LFSR_RESET;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      lfsr_r  <= lfsr_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    seed_r <= seed_nxt;
  end

endmodule

// File: sv/toeplitz_randomness_extractor.sv
// ----------------------------------------------------------------------------
// toeplitz_randomness_extractor
// GF(2) Toeplitz hashing of raw random words into shorter extracted words.
// ----------------------------------------------------------------------------
// Each input item is one raw word; each result item holds the parities of the
// raw word ANDed with the OUT_WIDTH rows of a Toeplitz matrix. The matrix
// seed is the bit-0 stream of a 32-bit right-shifting LFSR (taps 0, 1, 21, 31)
// loaded from the configuration register. After reset, and after every
// configuration write, the seed is rebuilt one bit per cycle; in_tready stays
// low meanwhile. Once the seed is ready the block takes one item per clock
// while intake is not stalled; each raw word is held in the input register,
// then a bank of parity trees loads its result into the result register,
// which drives out_tvalid. Back-pressure on the output only stalls intake
// once both registers are full.
// ----------------------------------------------------------------------------
module toeplitz_randomness_extractor #(
  parameter int unsigned RAW_WIDTH = tre_pkg::RAW_WIDTH_DEF,
  parameter int unsigned OUT_WIDTH = tre_pkg::OUT_WIDTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // configuration write channel
  input  logic                             cfg_tvalid,
  output logic                             cfg_tready,
  input  logic [tre_pkg::LFSR_W-1:0]       cfg_tdata,    // [31:0] lfsr_start
  // raw input stream
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [tre_pkg::RAW_FIELD_W-1:0]  in_tdata,     // [63:0] raw_word
  // extracted output stream
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [tre_pkg::OUT_FIELD_W-1:0]  out_tdata     // [31:0] extracted_word
);

  localparam int unsigned SEED_W   = RAW_WIDTH + OUT_WIDTH - 1;
  localparam int unsigned EXT_W    = (OUT_WIDTH > tre_pkg::OUT_FIELD_W) ?
                                     OUT_WIDTH : tre_pkg::OUT_FIELD_W;

  logic [SEED_W-1:0]               seed;
  logic                            seed_ok;

  // input register
  logic                            s1_valid_r;
  logic [RAW_WIDTH-1:0]            raw_r;
  // result register
  logic                            out_valid_r;
  logic [tre_pkg::OUT_FIELD_W-1:0] out_data_r;

  logic                            s2_ready;
  logic                            s1_ready;
  logic                            in_acc;
  logic                            s1_move;
  logic [RAW_WIDTH-1:0]            raw_rev;
  logic [OUT_WIDTH-1:0]            res_full;
  logic [EXT_W-1:0]                res_ext;

  tre_seed_gen #(
    .SEED_W (SEED_W)
  ) u_seed_gen (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_tvalid (cfg_tvalid),
    .cfg_tready (cfg_tready),
    .cfg_tdata  (cfg_tdata),
    .seed       (seed),
    .seed_ok    (seed_ok)
  );

  // Handshake: each stage takes a new item when empty or draining
  assign s2_ready  = !out_valid_r || out_tready;
  assign s1_ready  = !s1_valid_r || s2_ready;
  assign in_tready = s1_ready && seed_ok;
  assign in_acc    = in_tvalid && in_tready;
  assign s1_move   = s1_valid_r && s2_ready;

  // Raw bit j (first bit first) sits at word bit RAW_WIDTH-1-j
  always_comb begin
    for (int j = 0; j < RAW_WIDTH; j++) begin
      raw_rev[j] = raw_r[RAW_WIDTH-1-j];
    end
  end

  // One parity tree per matrix row; row i is seed[i +: RAW_WIDTH]
  always_comb begin
    for (int i = 0; i < OUT_WIDTH; i++) begin
      res_full[OUT_WIDTH-1-i] = ^(raw_rev & seed[i +: RAW_WIDTH]);
    end
  end

  // Rows beyond the output field are dropped, missing ones read as zero
  assign res_ext = EXT_W'(res_full);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (s1_ready) begin
        s1_valid_r <= in_acc;
      end
      if (s2_ready) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      raw_r <= in_tdata[RAW_WIDTH-1:0];
    end
    if (s1_move) begin
      out_data_r <= res_ext[tre_pkg::OUT_FIELD_W-1:0];
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule
